>>> hw/rtl/hse_pkg.sv
// Shared types, constants and control structs of the Huffman symbol encoder.
package hse_pkg;

    localparam int MAX_CODE_LEN  = 24;
    localparam int SYMBOL_COUNT  = 256;

    localparam int SYM_W         = 8;
    localparam int CODE_W        = 24;
    localparam int LEN_W         = 5;
    localparam int SYM_IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int PEND_W        = 7;
    localparam int ACC_W         = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W         = $clog2(ACC_W + 1);
    localparam int ENTRY_W       = CODE_W + LEN_W;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } hse_in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] valid_bits;
        logic       last;
    } hse_out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_FLUSH
    } hse_state_t;

    typedef struct packed {
        logic wr_entry;
        logic rd_entry;
        logic build;
        logic emit_byte;
        logic emit_flush;
    } hse_cmd_t;

    typedef struct packed {
        logic sym_ok;
        logic sum_ge8;
        logic pend_nz;
        logic emit_last;
    } hse_stat_t;

endpackage

>>> hw/rtl/hse_datapath.sv
// Datapath: code table memory, bit accumulator and output word register.
module hse_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hse_pkg::hse_in_word_t in_word,
    input  hse_pkg::hse_cmd_t     cmd,
    output hse_pkg::hse_stat_t    stat,
    output hse_pkg::hse_out_word_t out_word
);
    import hse_pkg::*;

    logic [ENTRY_W-1:0] code_table [SYMBOL_COUNT];
    logic [ENTRY_W-1:0] entry_reg;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    hse_out_word_t      out_reg, out_next;

    logic [SYM_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     len_sat;
    logic [LEN_W-1:0]     ent_len;
    logic [CODE_W-1:0]    ent_code;
    logic [PEND_W-1:0]    pend;
    logic [2:0]           pend_cnt;
    logic [TOT_W-1:0]     sum_total;
    logic [ACC_W-1:0]     sum_acc;
    logic [TOT_W-1:0]     emit_shift;

    assign idx     = in_word.symbol[SYM_IDX_W-1:0];
    assign len_sat = (in_word.code_length > LEN_W'(MAX_CODE_LEN)) ?
                     LEN_W'(MAX_CODE_LEN) : in_word.code_length;

    // Table write on load, registered read on encode.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            code_table[idx] <= {len_sat, in_word.code_value};
        end
        if (cmd.rd_entry)
        begin
            entry_reg <= code_table[idx];
        end
    end

    assign ent_len  = entry_reg[ENTRY_W-1:CODE_W];
    assign ent_code = entry_reg[CODE_W-1:0] & ({CODE_W{1'b1}} >> (LEN_W'(CODE_W) - ent_len));

    // Waiting bits sit right-aligned in the accumulator with fewer than eight left.
    assign pend_cnt  = total_reg[2:0];
    assign pend      = acc_reg[PEND_W-1:0] & ({PEND_W{1'b1}} >> (3'd7 - pend_cnt));
    assign sum_acc   = (ACC_W'(pend) << ent_len) | ACC_W'(ent_code);
    assign sum_total = total_reg + TOT_W'(ent_len);
    assign emit_shift = total_reg - TOT_W'(8);

    assign stat.sym_ok    = ({1'b0, in_word.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign stat.sum_ge8   = (sum_total >= TOT_W'(8));
    assign stat.pend_nz   = (pend_cnt != 3'd0);
    assign stat.emit_last = (total_reg < TOT_W'(16));

    always_comb
    begin
        acc_next   = acc_reg;
        total_next = total_reg;
        out_next   = out_reg;
        if (cmd.build)
        begin
            acc_next   = sum_acc;
            total_next = sum_total;
        end
        if (cmd.emit_byte)
        begin
            out_next.out_byte   = 8'(acc_reg >> emit_shift);
            out_next.valid_bits = 4'd8;
            out_next.last       = stat.emit_last;
            total_next          = emit_shift;
        end
        if (cmd.emit_flush)
        begin
            // Left-align the partial byte, zero-pad below.
            out_next.out_byte   = 8'({1'b0, pend} << (4'd8 - {1'b0, pend_cnt}));
            out_next.valid_bits = {1'b0, pend_cnt};
            out_next.last       = 1'b1;
            acc_next            = '0;
            total_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_word = out_reg;

endmodule

>>> hw/rtl/hse_ctrl.sv
// Controller: sequences load, lookup, byte emission and flush.
module hse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_stall,
    input  logic [1:0]         kind,
    output logic               byte_valid,
    input  logic               byte_stall,
    input  hse_pkg::hse_stat_t stat,
    output hse_pkg::hse_cmd_t  cmd
);
    import hse_pkg::*;

    hse_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        sym_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sym_stall = 1'b0;
                if (sym_valid)
                begin
                    case (kind)
                        KIND_LOAD:
                        begin
                            cmd.wr_entry = stat.sym_ok;
                        end
                        KIND_ENCODE:
                        begin
                            if (stat.sym_ok)
                            begin
                                cmd.rd_entry = 1'b1;
                                state_next   = ST_LOOKUP;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            if (stat.pend_nz)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                cmd.build  = 1'b1;
                state_next = stat.sum_ge8 ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // Advance one byte per free output slot.
                if (slot_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_byte || cmd.emit_flush)
        begin
            out_valid_next = 1'b1;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign byte_valid = out_valid_reg;

endmodule

>>> hw/rtl/huffman_symbol_encoder.sv
// Top level of the table-driven Huffman symbol encoder.
//
//   channel  | handshake               | word
//   ---------+-------------------------+----------------------------------
//   sym      | sym_valid / sym_stall   | kind, symbol, code_value, code_length
//   byte     | byte_valid / byte_stall | out_byte, valid_bits, last
//
// A load word is written to the table as it is taken. An encode word reads
// the table, accumulates in ST_LOOKUP and emits each byte in ST_EMIT; a flush
// emits its partial byte from ST_FLUSH. Reset clears the controller and the
// pending bits; the code table is not cleared. A stall on the byte side holds
// the output word and pauses emission; a new word is taken while the last
// byte still waits.
module huffman_symbol_encoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sym_valid,
    output logic                   sym_stall,
    input  hse_pkg::hse_in_word_t  sym_word,
    output logic                   byte_valid,
    input  logic                   byte_stall,
    output hse_pkg::hse_out_word_t byte_word
);
    import hse_pkg::*;

    hse_cmd_t  cmd;
    hse_stat_t stat;

    hse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .kind       (sym_word.kind),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    hse_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (sym_word),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (byte_word)
    );

endmodule

>>> tb/huffman_symbol_encoder_tb.sv
// Self-checking testbench of the Huffman symbol encoder: directed and random words.
module huffman_symbol_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hse_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 16;
    localparam int RANDOM_WORDS = 390;
    localparam int QUIET_WORDS  = 60;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          sym_valid = 1'b0;
    logic          sym_stall;
    hse_in_word_t  sym_word = '0;
    logic          byte_valid;
    logic          byte_stall = 1'b0;
    hse_out_word_t byte_word;

    // predictor state
    logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
    logic [6:0]        pend_bits;
    logic [2:0]        pend_cnt;
    hse_out_word_t     byte_q[$];

    // symbols whose entry has been loaded; only these are encoded
    logic              sym_loaded [SYMBOL_COUNT];
    int                loaded_syms[$];

    logic              idle_on = 1'b1;
    int                stall_left = 0;
    int                idle_cycles = 0;
    int                fail_count = 0;
    hse_out_word_t     exp_w;

    huffman_symbol_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_word   (sym_word),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Work out the bytes one accepted word causes and queue them.
    task automatic predict_bytes(input hse_in_word_t w);
        logic [LEN_W-1:0] len;
        logic [31:0]      code;
        logic [31:0]      acc;
        logic [15:0]      flush_bits;
        int               total;
        int               n_out;
        hse_out_word_t    r;
        case (w.kind)
            KIND_LOAD:
            begin
                len = (w.code_length > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : w.code_length;
                code_tbl[w.symbol] = w.code_value;
                len_tbl[w.symbol]  = len;
            end
            KIND_ENCODE:
            begin
                len = len_tbl[w.symbol];
                if (len != 0)
                begin
                    code  = 32'(code_tbl[w.symbol]) & ((32'h1 << len) - 32'h1);
                    acc   = (32'(pend_bits) << len) | code;
                    total = int'(pend_cnt) + int'(len);
                    n_out = total / 8;
                    for (int k = 0; k < n_out; k++)
                    begin
                        total        = total - 8;
                        r.out_byte   = 8'(acc >> total);
                        r.valid_bits = 4'd8;
                        r.last       = (k == n_out - 1);
                        byte_q.insert(byte_q.size(), r);
                    end
                    pend_bits = 7'(acc & ((32'h1 << total) - 32'h1));
                    pend_cnt  = 3'(total);
                end
            end
            KIND_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    flush_bits   = 16'(pend_bits) << (8 - int'(pend_cnt));
                    r.out_byte   = flush_bits[7:0];
                    r.valid_bits = 4'(pend_cnt);
                    r.last       = 1'b1;
                    byte_q.insert(byte_q.size(), r);
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Enter and leave at a falling edge; hold the word until it is taken.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] symbol,
                             input logic [23:0] value, input logic [4:0] length);
        hse_in_word_t w;
        int           gap;
        w.kind        = kind;
        w.symbol      = symbol;
        w.code_value  = value;
        w.code_length = length;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            sym_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sym_valid <= 1'b1;
        sym_word  <= w;
        forever
        begin
            @(posedge clk);
            if (!sym_stall)
                break;
        end
        predict_bytes(w);
        if (kind == KIND_LOAD && !sym_loaded[symbol])
        begin
            sym_loaded[symbol] = 1'b1;
            loaded_syms.insert(loaded_syms.size(), int'(symbol));
        end
        @(negedge clk);
    endtask

    task automatic test_table_load();
        send_word(KIND_LOAD, 8'd0,   24'hFFFFFF, 5'd1);   // excess value bits
        send_word(KIND_LOAD, 8'd255, 24'hABCDEF, 5'd24);
        send_word(KIND_LOAD, 8'd1,   24'h000000, 5'd31);  // overlong, saturates
        send_word(KIND_LOAD, 8'd2,   24'h000005, 5'd0);   // no code
        send_word(KIND_LOAD, 8'd3,   24'h000002, 5'd3);
    endtask

    task automatic test_ignored_words();
        send_word(KIND_UNUSED, 8'hFF, 24'hFFFFFF, 5'd31);
        send_word(KIND_FLUSH,  8'h00, 24'h000000, 5'd0);  // nothing pending
        send_word(KIND_ENCODE, 8'd2,  24'h000000, 5'd0);  // zero code length
    endtask

    task automatic test_encode_bytes();
        send_word(KIND_ENCODE, 8'd0,   24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd255, 24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd1,   24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd3,   24'h0, 5'd0);
        send_word(KIND_FLUSH,  8'd0,   24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd255, 24'h0, 5'd0);     // byte aligned, no remainder
    endtask

    task automatic test_flush_partial();
        send_word(KIND_ENCODE, 8'd3, 24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd3, 24'h0, 5'd0);
        send_word(KIND_ENCODE, 8'd0, 24'h0, 5'd0);
        send_word(KIND_FLUSH,  8'd0, 24'h0, 5'd0);       // seven bits pending
        send_word(KIND_FLUSH,  8'd0, 24'h0, 5'd0);
        send_word(KIND_UNUSED, 8'h00, 24'h000000, 5'd0);
    endtask

    task automatic test_random_stream();
        int          sent;
        int          pick;
        logic [4:0]  len;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent == RANDOM_WORDS - QUIET_WORDS)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                case ($urandom_range(0, 19))
                    0:       len = 5'd0;
                    1:       len = 5'($urandom_range(25, 31));
                    2, 3, 4: len = 5'($urandom_range(9, 24));
                    default: len = 5'($urandom_range(1, 8));
                endcase
                send_word(KIND_LOAD, 8'($urandom), 24'($urandom), len);
                sent++;
            end
            else if (pick < 85)
            begin
                send_word(KIND_ENCODE,
                          8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
                          24'($urandom), 5'($urandom));
                sent++;
            end
            else if (pick < 95)
            begin
                send_word(KIND_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom));
                sent++;
            end
            else
            begin
                // noise word, the block drops it
                send_word(KIND_UNUSED, 8'($urandom), 24'($urandom), 5'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        pend_bits = '0;
        pend_cnt  = '0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
            sym_loaded[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_table_load();
        test_ignored_words();
        test_encode_bytes();
        test_flush_partial();
        test_random_stream();

        sym_valid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && byte_q.size() == 0)
            $display("huffman_symbol_encoder_tb OK");
        else
            $display("huffman_symbol_encoder_tb NOT OK");
        $finish;
    end

    // Output stall bursts; no new burst starts once idling is switched off.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                byte_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                byte_stall <= 1'b1;
            end
            else
                byte_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (byte_q.size() == 0)
            begin
                $error("unexpected byte word %h", byte_word);
                fail_count++;
            end
            else
            begin
                exp_w = byte_q.pop_front();
                if (byte_word.out_byte !== exp_w.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", exp_w.out_byte, byte_word.out_byte);
                    fail_count++;
                end
                if (byte_word.valid_bits !== exp_w.valid_bits)
                begin
                    $error("valid_bits: expected %0d, got %0d",
                           exp_w.valid_bits, byte_word.valid_bits);
                    fail_count++;
                end
                if (byte_word.last !== exp_w.last)
                begin
                    $error("last: expected %0b, got %0b", exp_w.last, byte_word.last);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no word taken on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sym_valid && !sym_stall) || (byte_valid && !byte_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("huffman_symbol_encoder_tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> filelist.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_datapath.sv
hw/rtl/hse_ctrl.sv
hw/rtl/huffman_symbol_encoder.sv
tb/huffman_symbol_encoder_tb.sv
